/* hdl/fpwe_pkg.sv */
// Shared types, constants and the tap weight table for the band energy front end.
`default_nettype none
package fpwe_pkg;

    localparam int unsigned W_SAMPLE = 10;
    localparam int unsigned W_FILT   = 16;
    localparam int unsigned W_POW    = 29;
    localparam int unsigned W_BLK    = 35;
    localparam int unsigned W_SUM    = 40;
    localparam int unsigned W_INTV   = 7;
    localparam int unsigned W_CNT    = 6;
    localparam int unsigned W_TDATA  = 176;

    localparam logic [W_INTV-1:0] INTERVAL_RESET = 7'd25;
    localparam logic [W_INTV-1:0] INTERVAL_MAX   = 7'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILT,
        ST_DRAIN,
        ST_SQ,
        ST_BLK,
        ST_RING,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        WT_ZERO,
        WT_POS,
        WT_NEG
    } t_weight;

    typedef struct packed {
        logic accept;
        logic tap_rd;
        logic sq;
        logic blk;
        logic ring;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic last_tap;
        logic blk_done;
        logic out_free;
    } t_dp_sts;

    // band-pass kernel: three positive lobes, two negative lobes
    function automatic t_weight tap_weight(input int unsigned tap);
        t_weight w;
        w = WT_ZERO;
        if ((tap >= 22 && tap <= 28) || (tap >= 46 && tap <= 54) ||
            (tap >= 72 && tap <= 78)) begin
            w = WT_POS;
        end else if ((tap >= 34 && tap <= 41) || (tap >= 59 && tap <= 66)) begin
            w = WT_NEG;
        end
        return w;
    endfunction

endpackage
`default_nettype wire

/* hdl/fpwe_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module fpwe_ram #(
    parameter int unsigned WIDTH = 10,
    parameter int unsigned DEPTH = 100,
    parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* hdl/fpwe_datapath.sv */
// Datapath: delay line sweep, squarer, block accumulator, energy ring and output register.
`default_nettype none
module fpwe_datapath #(
    parameter int unsigned TAPS         = 100,
    parameter int unsigned WINDOW_DEPTH = 30
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_wr_en,
    input  wire logic [fpwe_pkg::W_INTV-1:0]       i_cfg_wr_data,
    input  wire logic [fpwe_pkg::W_SAMPLE-1:0]     i_adc_sample,
    input  wire fpwe_pkg::t_dp_cmd                 i_cmd,
    output fpwe_pkg::t_dp_sts                      o_sts,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    output logic [fpwe_pkg::W_TDATA-1:0]           o_m_tdata,
    output logic                                   o_m_tuser
);
    import fpwe_pkg::*;

    localparam int unsigned AW  = $clog2(TAPS);
    localparam int unsigned FW  = $clog2(TAPS + 1);
    localparam int unsigned RW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned RFW = $clog2(WINDOW_DEPTH + 1);

    logic [AW-1:0]              r_head, n_head;
    logic [FW-1:0]              r_fill;
    logic [AW-1:0]              r_k, r_k_d;
    logic                       r_acc_en;
    logic signed [W_FILT-1:0]   r_acc, n_acc;
    logic [W_SAMPLE-1:0]        r_centered;
    logic [W_POW-1:0]           r_sq;
    logic [W_BLK-1:0]           r_partial;
    logic [W_CNT-1:0]           r_cnt;
    logic [W_BLK-1:0]           r_block;
    logic                       r_upd;
    logic [RW-1:0]              r_slot;
    logic [RFW-1:0]             r_ring_fill;
    logic [W_SUM-1:0]           r_window, r_prev;
    logic [W_INTV-1:0]          r_interval;
    logic                       r_out_valid;

    logic [AW:0]                pos_sum;
    logic [AW-1:0]              rd_addr;
    logic [W_SAMPLE-1:0]        centered;
    logic [W_SAMPLE-1:0]        dl_rdata;
    logic signed [W_FILT-1:0]   tap_ext;
    logic [W_BLK-1:0]           ring_rdata;
    logic [W_BLK-1:0]           evicted;
    logic [W_INTV-1:0]          eff_interval;
    logic [W_INTV-1:0]          cnt_inc;
    logic                       blk_done;
    logic [W_BLK-1:0]           partial_sum;
    logic signed [2*W_FILT-1:0] product;

    // subtracting 512 from a 10-bit code flips its top bit
    assign centered = {~i_adc_sample[W_SAMPLE-1], i_adc_sample[W_SAMPLE-2:0]};
    assign n_head   = (r_head == '0) ? AW'(TAPS - 1) : r_head - AW'(1);

    // tap k sits k places after the newest sample, modulo the line length
    assign pos_sum = {1'b0, r_head} + {1'b0, r_k};
    assign rd_addr = (pos_sum >= (AW+1)'(TAPS)) ? AW'(pos_sum - (AW+1)'(TAPS))
                                                : pos_sum[AW-1:0];

    fpwe_ram #(
        .WIDTH (W_SAMPLE),
        .DEPTH (TAPS),
        .AW    (AW)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept),
        .i_waddr (n_head),
        .i_wdata (centered),
        .i_raddr (rd_addr),
        .o_rdata (dl_rdata)
    );

    fpwe_ram #(
        .WIDTH (W_BLK),
        .DEPTH (WINDOW_DEPTH),
        .AW    (RW)
    ) u_ring_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ring),
        .i_waddr (r_slot),
        .i_wdata (r_block),
        .i_raddr (r_slot),
        .o_rdata (ring_rdata)
    );

    assign tap_ext = W_FILT'(signed'(dl_rdata));

    always_comb begin
        n_acc = r_acc;
        // taps beyond the samples seen so far are skipped, since the line RAM is never cleared
        if (r_acc_en && (FW'(r_k_d) < r_fill)) begin
            case (tap_weight(32'(r_k_d)))
                WT_POS:  n_acc = r_acc + tap_ext;
                WT_NEG:  n_acc = r_acc - tap_ext;
                default: n_acc = r_acc;
            endcase
        end
    end

    assign product = r_acc * r_acc;

    always_comb begin
        if (r_interval == '0) begin
            eff_interval = W_INTV'(1);
        end else if (r_interval > INTERVAL_MAX) begin
            eff_interval = INTERVAL_MAX;
        end else begin
            eff_interval = r_interval;
        end
    end

    assign cnt_inc     = {1'b0, r_cnt} + W_INTV'(1);
    assign blk_done    = (cnt_inc >= eff_interval);
    assign partial_sum = r_partial + W_BLK'(r_sq);
    assign evicted     = (r_ring_fill == RFW'(WINDOW_DEPTH)) ? ring_rdata : '0;

    assign o_sts.last_tap = (r_k == AW'(TAPS - 1));
    assign o_sts.blk_done = blk_done;
    assign o_sts.out_free = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_acc_en    <= 1'b0;
            r_partial   <= '0;
            r_cnt       <= '0;
            r_slot      <= '0;
            r_ring_fill <= '0;
            r_window    <= '0;
            r_prev      <= '0;
            r_interval  <= INTERVAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_interval <= i_cfg_wr_data;
            end
            r_acc_en <= i_cmd.tap_rd;
            if (i_cmd.accept) begin
                r_head <= n_head;
                r_k    <= '0;
                if (r_fill != FW'(TAPS)) begin
                    r_fill <= r_fill + FW'(1);
                end
            end else if (i_cmd.tap_rd) begin
                r_k <= r_k + AW'(1);
            end
            if (i_cmd.blk) begin
                if (blk_done) begin
                    r_partial <= '0;
                    r_cnt     <= '0;
                end else begin
                    r_partial <= partial_sum;
                    r_cnt     <= W_CNT'(cnt_inc);
                end
            end
            if (i_cmd.ring) begin
                r_slot   <= (r_slot == RW'(WINDOW_DEPTH - 1)) ? '0 : r_slot + RW'(1);
                r_prev   <= r_window;
                r_window <= r_window + W_SUM'(r_block) - W_SUM'(evicted);
                if (r_ring_fill != RFW'(WINDOW_DEPTH)) begin
                    r_ring_fill <= r_ring_fill + RFW'(1);
                end
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_k_d <= r_k;
        if (i_cmd.accept) begin
            r_acc      <= '0;
            r_centered <= centered;
        end else begin
            r_acc <= n_acc;
        end
        if (i_cmd.sq) begin
            r_sq <= W_POW'(product);
        end
        if (i_cmd.blk) begin
            r_upd   <= blk_done;
            r_block <= blk_done ? partial_sum : '0;
        end
        if (i_cmd.load_out) begin
            o_m_tdata <= {6'd0, r_prev, r_window, r_block, r_sq, r_acc, r_centered};
            o_m_tuser <= r_upd;
        end
    end

    assign o_m_tvalid = r_out_valid;

`ifndef ASSERT_OFF
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= FW'(TAPS)) && (r_ring_fill <= RFW'(WINDOW_DEPTH)))
        else $error("fill count beyond depth");
    a_block_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.blk && !blk_done |=> (r_block == '0) && !r_upd)
        else $error("block energy shown without an update");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        W_INTV'(r_cnt) < INTERVAL_MAX)
        else $error("block sample count out of range");
`endif

endmodule
`default_nettype wire

/* hdl/fpwe_ctrl.sv */
// Controller: sequences tap sweep, squaring, block update, ring update and output load.
`default_nettype none
module fpwe_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire fpwe_pkg::t_dp_sts i_sts,
    output fpwe_pkg::t_dp_cmd      o_cmd
);
    import fpwe_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                // take no beat while reset is held
                o_s_tready   = i_rst_n;
                o_cmd.accept = i_s_tvalid && i_rst_n;
                if (i_s_tvalid) begin
                    n_state = ST_FILT;
                end
            end
            ST_FILT: begin
                o_cmd.tap_rd = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                // last tap lands in the accumulator this cycle
                n_state = ST_SQ;
            end
            ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = ST_BLK;
            end
            ST_BLK: begin
                o_cmd.blk = 1'b1;
                n_state   = i_sts.blk_done ? ST_RING : ST_OUT;
            end
            ST_RING: begin
                o_cmd.ring = 1'b1;
                n_state    = ST_OUT;
            end
            ST_OUT: begin
                // hold until the previous beat has left
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.accept |=> (r_state == ST_FILT))
        else $error("accepted sample did not start the tap sweep");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> i_sts.out_free)
        else $error("output register overwritten while held");
`endif

endmodule
`default_nettype wire

/* hdl/fir_power_window_energy_top.sv */
// Top level: band energy front end with FIR, squarer, block energy and sliding window sum.
//
//  channel  | dir | handshake                     | payload
//  s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata[9:0] adc_sample
//  m_axis   | out | m_axis_tvalid / m_axis_tready | tdata 176 bits, tuser energy_updated
//  cfg      | in  | i_cfg_wr_en                   | i_cfg_wr_data[6:0] update_interval
//
//  States per sample: sweep, drain, square, block, ring if it closes a block, output;
//  the sweep reads the delay line RAM one tap per cycle through its single read port.
//  Reset is synchronous, active low; delay line and energy ring use fill counts, so no
//  clearing pass is run and a sample can be taken in the first cycle after reset.
//  A finished beat waits in the output register while the next sample is filtered; the
//  block waits to load only while that beat has not been taken when the next one is ready.
`default_nettype none
module fir_power_window_energy_top #(
    parameter int unsigned TAPS         = 100,
    parameter int unsigned WINDOW_DEPTH = 30
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_cfg_wr_en,
    input  wire logic [fpwe_pkg::W_INTV-1:0]  i_cfg_wr_data,   // update_interval
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [15:0]                  s_axis_tdata,    // [9:0] adc_sample
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [9:0] centered_sample, [25:10] filtered_value, [54:26] sample_power,
    // [89:55] block_energy, [129:90] window_sum, [169:130] previous_window_sum
    output logic [fpwe_pkg::W_TDATA-1:0]      m_axis_tdata,
    output logic                              m_axis_tuser     // [0] energy_updated
);
    import fpwe_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    fpwe_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    fpwe_datapath #(
        .TAPS         (TAPS),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_adc_sample  (s_axis_tdata[W_SAMPLE-1:0]),
        .i_cmd         (dp_cmd),
        .o_sts         (dp_sts),
        .o_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .o_m_tdata     (m_axis_tdata),
        .o_m_tuser     (m_axis_tuser)
    );

endmodule
`default_nettype wire

/* test/tb.sv */
// Self-checking testbench for the band energy front end: FIR, squarer, block energy, window sum.
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import fpwe_pkg::*;

    localparam int N_TAPS    = 100;
    localparam int N_BLOCKS  = 30;
    localparam int N_CENTER  = 512;
    localparam int SPAN_MAX  = 64;

    typedef struct {
        logic [W_SAMPLE-1:0] centered;
        logic [W_FILT-1:0]   filtered;
        logic [W_POW-1:0]    power;
        logic                updated;
        logic [W_BLK-1:0]    block;
        logic [W_SUM-1:0]    wsum;
        logic [W_SUM-1:0]    prev;
    } t_band_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_wr_en;
    logic [W_INTV-1:0]   i_cfg_wr_data;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [15:0]         s_axis_tdata;     // [9:0] adc_sample
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [9:0] centered, [25:10] filtered, [54:26] power, [89:55] block,
    // [129:90] window sum, [169:130] previous window sum
    logic [W_TDATA-1:0]  m_axis_tdata;
    logic                m_axis_tuser;     // [0] energy_updated

    // predictor state
    logic signed [W_SAMPLE-1:0] sample_taps [0:N_TAPS-1];
    logic [W_BLK-1:0]           block_ring [0:N_BLOCKS-1];
    int                         ring_slot;
    logic [W_BLK-1:0]           block_accum;
    int                         block_count;
    logic [W_SUM-1:0]           window_total;
    logic [W_SUM-1:0]           window_prior;
    logic [W_INTV-1:0]          interval_reg;

    t_band_result pending_results [$];
    t_band_result want_beat;

    int  errors;
    int  items_sent;
    int  beats_checked;
    int  blocks_seen;
    int  interval_writes;
    bit  no_idle;
    int  ready_hold;

    fir_power_window_energy_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic int kernel_coef(input int k);
        if ((k >= 22 && k <= 28) || (k >= 46 && k <= 54) || (k >= 72 && k <= 78)) begin
            return 1;
        end
        if ((k >= 34 && k <= 41) || (k >= 59 && k <= 66)) begin
            return -1;
        end
        return 0;
    endfunction

    task automatic clear_band_state();
        for (int k = 0; k < N_TAPS; k++) sample_taps[k] = '0;
        for (int k = 0; k < N_BLOCKS; k++) block_ring[k] = '0;
        ring_slot    = 0;
        block_accum  = '0;
        block_count  = 0;
        window_total = '0;
        window_prior = '0;
        interval_reg = INTERVAL_RESET;
    endtask

    task automatic predict_band_energy(input logic [W_SAMPLE-1:0] adc);
        t_band_result r;
        int           acc;
        int           span;
        longint       sq;
        logic [W_BLK-1:0] evicted;
        // shift the delay line, tap 0 is the newest sample
        for (int k = N_TAPS - 1; k > 0; k--) sample_taps[k] = sample_taps[k-1];
        sample_taps[0] = $signed(adc - 10'(N_CENTER));
        acc = 0;
        for (int k = 0; k < N_TAPS; k++) acc += kernel_coef(k) * int'(sample_taps[k]);
        sq = longint'(acc) * longint'(acc);
        block_accum = block_accum + sq[W_BLK-1:0];
        block_count++;
        span = (interval_reg == 0) ? 1 :
               (interval_reg > SPAN_MAX) ? SPAN_MAX : int'(interval_reg);
        r.updated = (block_count >= span);
        r.block   = '0;
        if (r.updated) begin
            evicted                = block_ring[ring_slot];
            r.block                = block_accum;
            block_ring[ring_slot]  = block_accum;
            ring_slot              = (ring_slot + 1) % N_BLOCKS;
            window_prior           = window_total;
            window_total           = window_total + W_SUM'(block_accum) - W_SUM'(evicted);
            block_accum            = '0;
            block_count            = 0;
        end
        r.centered = sample_taps[0];
        r.filtered = acc[W_FILT-1:0];
        r.power    = sq[W_POW-1:0];
        r.wsum     = window_total;
        r.prev     = window_prior;
        pending_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [W_SUM-1:0] got,
                                   input logic [W_SUM-1:0] want);
        $display("mismatch %s at beat %0d: got %0h want %0h", what, beats_checked, got, want);
        errors++;
    endtask

    // drive one sample, with an optional idle burst ahead of it
    task automatic send_sample(input logic [W_SAMPLE-1:0] adc);
        int gap;
        @(negedge i_clk);
        if (!no_idle && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 9);
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'b0, adc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_band_energy(adc);
        items_sent++;
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // write the interval only once the block has gone quiet
    task automatic set_interval(input logic [W_INTV-1:0] value);
        drain_results();
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b1;
        i_cfg_wr_data = value;
        interval_reg  = value;
        interval_writes++;
        @(negedge i_clk);
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = 7'($urandom_range(0, 127));
    endtask

    function automatic logic [W_INTV-1:0] pick_interval();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return INTERVAL_MAX;
            3: return 7'd127;
            4: return 7'($urandom_range(65, 127));
            5: return 7'($urandom_range(2, 64));
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    // one run of samples in a random shape; returns how many were sent
    task automatic send_chunk(input int budget, output int sent);
        int           mode;
        int           len;
        bit           polarity;
        logic [W_SAMPLE-1:0] level;
        logic [W_SAMPLE-1:0] adc;
        mode     = $urandom_range(0, 5);
        len      = (mode == 4) ? N_TAPS : $urandom_range(5, 30);
        polarity = 1'($urandom_range(0, 1));
        level    = 10'($urandom_range(0, 1023));
        if (len > budget) len = budget;
        for (int i = 0; i < len; i++) begin
            case (mode)
                0, 1: adc = 10'($urandom_range(0, 1023));
                2:    adc = $urandom_range(0, 1) ? 10'h3FF : 10'h000;
                3:    adc = level;
                4: begin
                    // line up extreme samples with the kernel lobes when the run ends
                    case (kernel_coef(len - 1 - i))
                        1:       adc = polarity ? 10'h3FF : 10'h000;
                        -1:      adc = polarity ? 10'h000 : 10'h3FF;
                        default: adc = 10'($urandom_range(0, 1023));
                    endcase
                end
                default: adc = 10'(N_CENTER - 8 + $urandom_range(0, 16));
            endcase
            send_sample(adc);
        end
        sent = len;
    endtask

    task automatic run_phases(input int total);
        int done_items;
        int phase_len;
        int phase_items;
        int got;
        done_items = 0;
        while (done_items < total) begin
            set_interval(pick_interval());
            phase_len   = $urandom_range(40, 90);
            phase_items = 0;
            while (phase_items < phase_len && done_items < total) begin
                send_chunk(total - done_items, got);
                phase_items += got;
                done_items  += got;
            end
        end
    endtask

    task automatic test_sample_extremes();
        logic [W_SAMPLE-1:0] picks [9];
        picks = '{10'h000, 10'h3FF, 10'h200, 10'h1FF, 10'h201,
                  10'h155, 10'h2AA, 10'h001, 10'h3FE};
        foreach (picks[i]) send_sample(picks[i]);
    endtask

    task automatic test_interval_limits();
        set_interval(7'd0);          // zero behaves as one
        repeat (3) send_sample(10'($urandom_range(0, 1023)));
        set_interval(7'd1);
        repeat (2) send_sample(10'($urandom_range(0, 1023)));
        set_interval(INTERVAL_RESET);
        repeat (6) send_sample(10'($urandom_range(0, 1023)));
        set_interval(7'd3);          // already past the new interval mid-block
        repeat (2) send_sample(10'($urandom_range(0, 1023)));
    endtask

    task automatic test_random_traffic();
        run_phases(680);
    endtask

    task automatic test_back_to_back();
        drain_results();
        no_idle = 1'b1;
        run_phases(120);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("beat with no pending result", W_SUM'(m_axis_tuser), '0);
            end else begin
                want_beat = pending_results.pop_front();
                if (m_axis_tdata[9:0] !== want_beat.centered)
                    report_mismatch("centered_sample", W_SUM'(m_axis_tdata[9:0]),
                                    W_SUM'(want_beat.centered));
                if (m_axis_tdata[25:10] !== want_beat.filtered)
                    report_mismatch("filtered_value", W_SUM'(m_axis_tdata[25:10]),
                                    W_SUM'(want_beat.filtered));
                if (m_axis_tdata[54:26] !== want_beat.power)
                    report_mismatch("sample_power", W_SUM'(m_axis_tdata[54:26]),
                                    W_SUM'(want_beat.power));
                if (m_axis_tuser !== want_beat.updated)
                    report_mismatch("energy_updated", W_SUM'(m_axis_tuser),
                                    W_SUM'(want_beat.updated));
                if (m_axis_tdata[89:55] !== want_beat.block)
                    report_mismatch("block_energy", W_SUM'(m_axis_tdata[89:55]),
                                    W_SUM'(want_beat.block));
                if (m_axis_tdata[129:90] !== want_beat.wsum)
                    report_mismatch("window_sum", m_axis_tdata[129:90], want_beat.wsum);
                if (m_axis_tdata[169:130] !== want_beat.prev)
                    report_mismatch("previous_window_sum", m_axis_tdata[169:130],
                                    want_beat.prev);
                if (want_beat.updated) blocks_seen++;
            end
            beats_checked++;
        end
    end

    // output backpressure in random bursts
    initial begin
        m_axis_tready = 1'b1;
        ready_hold    = 0;
        forever begin
            @(negedge i_clk);
            if (no_idle) begin
                m_axis_tready = 1'b1;
            end else if (ready_hold > 0) begin
                ready_hold--;
            end else if ($urandom_range(0, 3) == 0) begin
                m_axis_tready = 1'b0;
                ready_hold    = $urandom_range(1, 9) - 1;
            end else begin
                m_axis_tready = 1'b1;
                ready_hold    = $urandom_range(0, 30);
            end
        end
    end

    initial begin
        i_rst_n         = 1'b0;
        i_cfg_wr_en     = 1'b0;
        i_cfg_wr_data   = '0;
        s_axis_tvalid   = 1'b0;
        s_axis_tdata    = '0;
        errors          = 0;
        items_sent      = 0;
        beats_checked   = 0;
        blocks_seen     = 0;
        interval_writes = 0;
        no_idle         = 1'b0;
        clear_band_state();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_sample_extremes();
        test_interval_limits();
        test_random_traffic();
        test_back_to_back();

        drain_results();
        repeat (120) @(posedge i_clk);
        $display("run covered %0d samples, %0d checked beats, %0d block updates",
                 items_sent, beats_checked, blocks_seen);
        $display("interval written %0d times, extremes and out-of-range values included",
                 interval_writes);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
`default_nettype wire
